@@ rtl/kts_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and codes for the keyed table search and delete block.
// ----------------------------------------------------------------------------
package kts_pkg;

	localparam int unsigned KEY_W    = 64;
	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned COUNT_W  = 8;
	localparam int unsigned STATUS_W = 2;

	// Operation codes carried by the mode field.
	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_LOOKUP = 2'd1,
		MODE_UPDATE = 2'd2,
		MODE_DELETE = 2'd3
	} mode_t;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

	// One table entry as it is stored in the memory.
	typedef struct packed {
		logic [KEY_W-1:0]   key_a;
		logic [KEY_W-1:0]   key_b;
		logic [VALUE_W-1:0] value;
	} entry_t;

endpackage
`default_nettype wire

@@ rtl/keyed_table_search_delete.sv @@
`default_nettype none
// Insert completes from the idle state; lookup or update scans from position 0 up to the
// match; a search that misses scans every held entry; delete scans to the match and then
// compacts (one compare per cycle up to the match, then one copy per later entry).
// Throughput: one transaction at a time; start is taken whenever busy is low, including the
// cycle of the previous result strobe. Results cannot be stalled. Reset clears count and control.
// ----------------------------------------------------------------------------
// keyed_table_search_delete
// Unsorted keyed table with insert, lookup, update and order-preserving delete.
// ----------------------------------------------------------------------------
module keyed_table_search_delete #(
	parameter int unsigned TABLE_DEPTH = 128
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        mode,
	input  wire logic [kts_pkg::KEY_W-1:0]         first_key,
	input  wire logic [kts_pkg::KEY_W-1:0]         second_key,
	input  wire logic [kts_pkg::VALUE_W-1:0]       entry_value,
	output logic                                   done,
	output logic [kts_pkg::STATUS_W-1:0]           status,
	output logic [kts_pkg::POS_W-1:0]              position,
	output logic [kts_pkg::VALUE_W-1:0]            found_value,
	output logic [kts_pkg::COUNT_W-1:0]            entry_count
);

	// Index width addresses every entry; the count needs one more value so it
	// can represent a full table.
	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	kts_pkg::entry_t   mem_wdata;
	logic [IDX_W-1:0]  mem_raddr;
	kts_pkg::entry_t   mem_rdata;

	// The sequencer owns the entry count and all transaction control. Entries
	// at or above the count are never read, so the memory needs no clearing.
	kts_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.mode        (mode),
		.key_a       (first_key),
		.key_b       (second_key),
		.value       (entry_value),
		.busy        (busy),
		.done        (done),
		.status      (status),
		.position    (position),
		.found_value (found_value),
		.entry_count (entry_count),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	// Both key parts and the value of an entry live side by side in one wide
	// memory word, so a single read returns everything a compare needs.
	kts_mem #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule
`default_nettype wire

@@ rtl/kts_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kts_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kts_mem #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned IDX_W = 7
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [IDX_W-1:0] waddr,
	input  wire kts_pkg::entry_t wdata,
	input  wire logic [IDX_W-1:0] raddr,
	output kts_pkg::entry_t      rdata
);

	kts_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ rtl/kts_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kts_ctrl
// Sequencer: appends, scans the memory for the first match, and compacts the
// table after a delete by copying each later entry down one place.
// ----------------------------------------------------------------------------
module kts_ctrl #(
	parameter int unsigned DEPTH = 128,
	parameter int unsigned IDX_W = 7,
	parameter int unsigned CNT_W = 8
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	input  wire logic [1:0]                     mode,
	input  wire logic [kts_pkg::KEY_W-1:0]      key_a,
	input  wire logic [kts_pkg::KEY_W-1:0]      key_b,
	input  wire logic [kts_pkg::VALUE_W-1:0]    value,
	output logic                                busy,
	output logic                                done,
	output logic [kts_pkg::STATUS_W-1:0]        status,
	output logic [kts_pkg::POS_W-1:0]           position,
	output logic [kts_pkg::VALUE_W-1:0]         found_value,
	output logic [kts_pkg::COUNT_W-1:0]         entry_count,
	output logic                                mem_we,
	output logic [IDX_W-1:0]                    mem_waddr,
	output kts_pkg::entry_t                     mem_wdata,
	output logic [IDX_W-1:0]                    mem_raddr,
	input  wire kts_pkg::entry_t                mem_rdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT
	} state_t;

	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

	state_t                           state_q;
	kts_pkg::mode_t                   mode_q;
	logic [kts_pkg::KEY_W-1:0]        key_a_q;
	logic [kts_pkg::KEY_W-1:0]        key_b_q;
	logic [kts_pkg::VALUE_W-1:0]      value_q;
	logic [CNT_W-1:0]                 count_q;
	logic [CNT_W-1:0]                 rd_idx_q;
	logic                             vld_s1;
	logic [IDX_W-1:0]                 idx_s1;
	logic [IDX_W-1:0]                 hit_q;
	logic                             done_q;
	logic [kts_pkg::STATUS_W-1:0]     status_q;
	logic [kts_pkg::POS_W-1:0]        pos_q;
	logic [kts_pkg::VALUE_W-1:0]      found_q;

	logic                             rd_more;
	logic                             hit;
	logic                             room;
	logic [CNT_W+kts_pkg::POS_W-1:0]  cnt_pad;
	logic [IDX_W+kts_pkg::POS_W-1:0]  idx_pad;
	logic [IDX_W+kts_pkg::POS_W-1:0]  hit_pad;
	logic [CNT_W+kts_pkg::COUNT_W-1:0] cnt_out_pad;

	assign rd_more = (rd_idx_q < count_q);
	assign hit     = vld_s1 && (mem_rdata.key_a == key_a_q) && (mem_rdata.key_b == key_b_q);
	assign room    = (count_q < DEPTH_C);

	assign cnt_pad     = {{kts_pkg::POS_W{1'b0}}, count_q};
	assign idx_pad     = {{kts_pkg::POS_W{1'b0}}, idx_s1};
	assign hit_pad     = {{kts_pkg::POS_W{1'b0}}, hit_q};
	assign cnt_out_pad = {{kts_pkg::COUNT_W{1'b0}}, count_q};

	assign mem_raddr = rd_idx_q[IDX_W-1:0];

	// Memory write selection. Reads run ahead of writes during compaction, so
	// the two ports never touch the same entry in one cycle.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[IDX_W-1:0];
		mem_wdata = '{key_a: key_a, key_b: key_b, value: value};
		unique case (state_q)
			ST_IDLE: begin
				mem_we = start && (kts_pkg::mode_t'(mode) == kts_pkg::MODE_INSERT) && room;
			end
			ST_SCAN: begin
				if (hit && (mode_q == kts_pkg::MODE_UPDATE)) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1;
					mem_wdata = '{key_a: key_a_q, key_b: key_b_q, value: value_q};
				end
			end
			ST_SHIFT: begin
				if (vld_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1 - IDX_W'(1);
					mem_wdata = mem_rdata;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			mode_q   <= kts_pkg::MODE_INSERT;
			key_a_q  <= '0;
			key_b_q  <= '0;
			value_q  <= '0;
			count_q  <= '0;
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
			hit_q    <= '0;
			done_q   <= 1'b0;
			status_q <= kts_pkg::STATUS_DONE;
			pos_q    <= '0;
			found_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					done_q <= start && (kts_pkg::mode_t'(mode) == kts_pkg::MODE_INSERT);
					if (start) begin
						mode_q   <= kts_pkg::mode_t'(mode);
						key_a_q  <= key_a;
						key_b_q  <= key_b;
						value_q  <= value;
						rd_idx_q <= '0;
						if (kts_pkg::mode_t'(mode) == kts_pkg::MODE_INSERT) begin
							found_q <= '0;
							if (room) begin
								status_q <= kts_pkg::STATUS_DONE;
								pos_q    <= cnt_pad[kts_pkg::POS_W-1:0];
								count_q  <= count_q + CNT_W'(1);
							end else begin
								status_q <= kts_pkg::STATUS_FULL;
								pos_q    <= '0;
							end
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					vld_s1 <= rd_more;
					idx_s1 <= rd_idx_q[IDX_W-1:0];
					done_q <= (hit && ((mode_q == kts_pkg::MODE_LOOKUP) ||
						(mode_q == kts_pkg::MODE_UPDATE))) || (!hit && !rd_more);
					if (rd_more) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (hit) begin
						unique case (mode_q)
							kts_pkg::MODE_LOOKUP: begin
								status_q <= kts_pkg::STATUS_DONE;
								pos_q    <= idx_pad[kts_pkg::POS_W-1:0];
								found_q  <= mem_rdata.value;
								state_q  <= ST_IDLE;
							end
							kts_pkg::MODE_UPDATE: begin
								status_q <= kts_pkg::STATUS_DONE;
								pos_q    <= idx_pad[kts_pkg::POS_W-1:0];
								found_q  <= '0;
								state_q  <= ST_IDLE;
							end
							kts_pkg::MODE_DELETE: begin
								hit_q   <= idx_s1;
								state_q <= ST_SHIFT;
							end
							kts_pkg::MODE_INSERT: begin
								state_q <= ST_IDLE;
							end
						endcase
					end else if (!rd_more) begin
						status_q <= kts_pkg::STATUS_MISSING;
						pos_q    <= '0;
						found_q  <= '0;
						state_q  <= ST_IDLE;
					end
				end
				ST_SHIFT: begin
					vld_s1 <= rd_more;
					idx_s1 <= rd_idx_q[IDX_W-1:0];
					done_q <= !vld_s1;
					if (rd_more) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (!vld_s1) begin
						status_q <= kts_pkg::STATUS_DONE;
						pos_q    <= hit_pad[kts_pkg::POS_W-1:0];
						found_q  <= '0;
						count_q  <= count_q - CNT_W'(1);
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign position    = pos_q;
	assign found_value = found_q;
	assign entry_count = cnt_out_pad[kts_pkg::COUNT_W-1:0];

endmodule
`default_nettype wire

@@ tb/sv/kts_table_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kts_table_checker
// Watches the command and result ports of the keyed table, keeps its own copy
// of the table, and compares every result with the predicted one.
// ----------------------------------------------------------------------------
module kts_table_checker #(
	parameter int unsigned TABLE_DEPTH = 128
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic                             busy,
	input  wire logic [1:0]                       mode,
	input  wire logic [kts_pkg::KEY_W-1:0]        first_key,
	input  wire logic [kts_pkg::KEY_W-1:0]        second_key,
	input  wire logic [kts_pkg::VALUE_W-1:0]      entry_value,
	input  wire logic                             done,
	input  wire logic [kts_pkg::STATUS_W-1:0]     status,
	input  wire logic [kts_pkg::POS_W-1:0]        position,
	input  wire logic [kts_pkg::VALUE_W-1:0]      found_value,
	input  wire logic [kts_pkg::COUNT_W-1:0]      entry_count,
	output int unsigned                           accepted_total,
	output int unsigned                           checked_total,
	output int unsigned                           full_total,
	output int unsigned                           error_total
);

	typedef struct packed {
		logic [kts_pkg::STATUS_W-1:0] status;
		logic [kts_pkg::POS_W-1:0]    position;
		logic [kts_pkg::VALUE_W-1:0]  found_value;
		logic [kts_pkg::COUNT_W-1:0]  entry_count;
	} table_reply_t;

	logic [kts_pkg::KEY_W-1:0]   shadow_key_a [TABLE_DEPTH];
	logic [kts_pkg::KEY_W-1:0]   shadow_key_b [TABLE_DEPTH];
	logic [kts_pkg::VALUE_W-1:0] shadow_value [TABLE_DEPTH];
	int unsigned                 shadow_count;
	table_reply_t                pending_replies [$];

	initial begin
		accepted_total = 0;
		checked_total  = 0;
		full_total     = 0;
		error_total    = 0;
		shadow_count   = 0;
	end

	// Applies one transaction to the shadow table and returns the reply it must produce.
	function automatic table_reply_t apply_table_op(kts_pkg::mode_t op,
			logic [kts_pkg::KEY_W-1:0] ka, logic [kts_pkg::KEY_W-1:0] kb,
			logic [kts_pkg::VALUE_W-1:0] val);
		table_reply_t reply;
		int           hit;
		reply        = '0;
		reply.status = kts_pkg::STATUS_DONE;
		hit          = -1;
		if (op == kts_pkg::MODE_INSERT) begin
			if (shadow_count >= TABLE_DEPTH) begin
				reply.status = kts_pkg::STATUS_FULL;
			end else begin
				reply.position             = kts_pkg::POS_W'(shadow_count);
				shadow_key_a[shadow_count] = ka;
				shadow_key_b[shadow_count] = kb;
				shadow_value[shadow_count] = val;
				shadow_count++;
			end
		end else begin
			for (int i = 0; i < int'(shadow_count); i++) begin
				if (hit < 0 && shadow_key_a[i] == ka && shadow_key_b[i] == kb)
					hit = i;
			end
			if (hit < 0) begin
				reply.status = kts_pkg::STATUS_MISSING;
			end else begin
				reply.position = kts_pkg::POS_W'(hit);
				case (op)
					kts_pkg::MODE_LOOKUP: reply.found_value = shadow_value[hit];
					kts_pkg::MODE_UPDATE: shadow_value[hit] = val;
					default: begin
						// Close the gap so the later entries keep their order.
						for (int j = hit; j + 1 < int'(shadow_count); j++) begin
							shadow_key_a[j] = shadow_key_a[j+1];
							shadow_key_b[j] = shadow_key_b[j+1];
							shadow_value[j] = shadow_value[j+1];
						end
						shadow_count--;
					end
				endcase
			end
		end
		reply.entry_count = kts_pkg::COUNT_W'(shadow_count);
		return reply;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		table_reply_t want;
		int unsigned  bad;
		bad = 0;
		if (!arst_n) begin
			shadow_count = 0;
			pending_replies.delete();
		end else begin
			if (done === 1'b1) begin
				if (pending_replies.size() == 0) begin
					$error("result with no transaction pending: status %0d position %0d",
						status, position);
					bad++;
				end else begin
					want = pending_replies.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						bad++;
					end
					if (position !== want.position) begin
						$error("position: expected %0d, got %0d", want.position, position);
						bad++;
					end
					if (found_value !== want.found_value) begin
						$error("found_value: expected %h, got %h", want.found_value,
							found_value);
						bad++;
					end
					if (entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count,
							entry_count);
						bad++;
					end
					if (want.status == kts_pkg::STATUS_FULL)
						full_total <= full_total + 1;
					checked_total <= checked_total + 1;
				end
			end
			if (start && !busy) begin
				pending_replies.push_back(apply_table_op(kts_pkg::mode_t'(mode), first_key,
					second_key, entry_value));
				accepted_total <= accepted_total + 1;
			end
			if (bad != 0)
				error_total <= error_total + bad;
		end
	end

endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the keyed table: a directed walk through the
// corner cases, then random insert, lookup, update and delete traffic over a
// small key pool, under three sender pacing phases. Checking is done by the
// table checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb;

	localparam int unsigned TABLE_DEPTH  = 128;
	// A search plus a compacting shift visits each entry at most twice, so this covers
	// the slowest transaction; the run limit leaves a wide margin over the slowest run.
	localparam int unsigned DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned POOL_SIZE    = 12;
	localparam int unsigned PHASE_ITEMS  = 200;

	localparam logic [kts_pkg::KEY_W-1:0]   KEY_ZERO = '0;
	localparam logic [kts_pkg::KEY_W-1:0]   KEY_ONES = '1;
	localparam logic [kts_pkg::KEY_W-1:0]   KEY_MIX  = 64'h0123_4567_89AB_CDEF;
	localparam logic [kts_pkg::VALUE_W-1:0] VAL_ALT1 = 64'hA5A5_A5A5_A5A5_A5A5;
	localparam logic [kts_pkg::VALUE_W-1:0] VAL_ALT2 = 64'h5A5A_5A5A_5A5A_5A5A;

	logic                           clk         = 1'b0;
	logic                           arst_n      = 1'b0;
	logic                           start       = 1'b0;
	logic [1:0]                     mode        = '0;
	logic [kts_pkg::KEY_W-1:0]      first_key   = '0;
	logic [kts_pkg::KEY_W-1:0]      second_key  = '0;
	logic [kts_pkg::VALUE_W-1:0]    entry_value = '0;
	logic                           busy;
	logic                           done;
	logic [kts_pkg::STATUS_W-1:0]   status;
	logic [kts_pkg::POS_W-1:0]      position;
	logic [kts_pkg::VALUE_W-1:0]    found_value;
	logic [kts_pkg::COUNT_W-1:0]    entry_count;

	int unsigned accepted_total;
	int unsigned checked_total;
	int unsigned full_total;
	int unsigned error_total;

	int unsigned                cycle_count = 0;
	int unsigned                sent_by_op [4];
	logic [kts_pkg::KEY_W-1:0]  pool_key_a [POOL_SIZE];
	logic [kts_pkg::KEY_W-1:0]  pool_key_b [POOL_SIZE];

	always #10 clk = ~clk;

	keyed_table_search_delete #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.mode       (mode),
		.first_key  (first_key),
		.second_key (second_key),
		.entry_value(entry_value),
		.done       (done),
		.status     (status),
		.position   (position),
		.found_value(found_value),
		.entry_count(entry_count)
	);

	kts_table_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table_watch (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.first_key     (first_key),
		.second_key    (second_key),
		.entry_value   (entry_value),
		.done          (done),
		.status        (status),
		.position      (position),
		.found_value   (found_value),
		.entry_count   (entry_count),
		.accepted_total(accepted_total),
		.checked_total (checked_total),
		.full_total    (full_total),
		.error_total   (error_total)
	);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	function automatic logic [63:0] rand_wide();
		return {$urandom, $urandom};
	endfunction

	// Presents one transaction and returns at the edge that accepts it. The sender first
	// idles at random for idle_pct percent of cycles; with no idling, start stays high
	// from one transaction to the next. Inputs are sampled right after the edge, before
	// the block's own updates land, so busy reads as it was at that edge.
	task automatic send_op(kts_pkg::mode_t op, logic [kts_pkg::KEY_W-1:0] ka,
			logic [kts_pkg::KEY_W-1:0] kb, logic [kts_pkg::VALUE_W-1:0] val,
			int unsigned idle_pct);
		while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		mode        <= op;
		first_key   <= ka;
		second_key  <= kb;
		entry_value <= val;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent_by_op[op]++;
	endtask

	// One random transaction. Keys come mostly from the pool so lookups, updates and
	// deletes find their targets; the rest are fresh keys that almost always miss.
	task automatic random_op(int unsigned insert_pct, int unsigned idle_pct);
		kts_pkg::mode_t            op;
		int unsigned               slot;
		logic [kts_pkg::KEY_W-1:0] ka;
		logic [kts_pkg::KEY_W-1:0] kb;
		if ($urandom_range(99) < insert_pct)
			op = kts_pkg::MODE_INSERT;
		else
			op = kts_pkg::mode_t'($urandom_range(int'(kts_pkg::MODE_DELETE),
				int'(kts_pkg::MODE_LOOKUP)));
		if ($urandom_range(99) < 85) begin
			slot = $urandom_range(POOL_SIZE - 1);
			ka   = pool_key_a[slot];
			kb   = pool_key_b[slot];
		end else begin
			ka = rand_wide();
			kb = rand_wide();
		end
		send_op(op, ka, kb, rand_wide(), idle_pct);
	endtask

	initial begin : stimulus
		foreach (sent_by_op[i])
			sent_by_op[i] = 0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Every search on the empty table must miss.
		send_op(kts_pkg::MODE_LOOKUP, KEY_ZERO, KEY_ZERO, rand_wide(), 0);
		send_op(kts_pkg::MODE_DELETE, KEY_ZERO, KEY_ZERO, rand_wide(), 0);
		send_op(kts_pkg::MODE_UPDATE, KEY_ONES, KEY_ONES, rand_wide(), 0);
		// Extreme keys and values, one pair sharing its first part with another, and
		// a duplicate of the first key at the end.
		send_op(kts_pkg::MODE_INSERT, KEY_ZERO, KEY_ZERO, KEY_ONES, 0);
		send_op(kts_pkg::MODE_INSERT, KEY_ONES, KEY_ONES, KEY_ZERO, 0);
		send_op(kts_pkg::MODE_INSERT, KEY_ONES, KEY_ZERO, VAL_ALT1, 0);
		send_op(kts_pkg::MODE_INSERT, KEY_ZERO, KEY_ZERO, VAL_ALT2, 0);
		// The lowest-indexed duplicate wins; a match on one key part alone is a miss.
		send_op(kts_pkg::MODE_LOOKUP, KEY_ZERO, KEY_ZERO, rand_wide(), 0);
		send_op(kts_pkg::MODE_LOOKUP, KEY_ONES, KEY_ONES, rand_wide(), 0);
		send_op(kts_pkg::MODE_LOOKUP, KEY_ZERO, KEY_ONES, rand_wide(), 0);
		send_op(kts_pkg::MODE_UPDATE, KEY_ZERO, KEY_ZERO, KEY_MIX, 0);
		send_op(kts_pkg::MODE_LOOKUP, KEY_ZERO, KEY_ZERO, rand_wide(), 0);
		send_op(kts_pkg::MODE_UPDATE, KEY_ZERO, KEY_MIX, rand_wide(), 0);
		// Delete from the middle, then check that the later entries moved down in order.
		send_op(kts_pkg::MODE_DELETE, KEY_ONES, KEY_ONES, rand_wide(), 0);
		send_op(kts_pkg::MODE_LOOKUP, KEY_ONES, KEY_ZERO, rand_wide(), 0);
		// Deleting the first copy of a duplicate exposes the second one.
		send_op(kts_pkg::MODE_DELETE, KEY_ZERO, KEY_ZERO, rand_wide(), 0);
		send_op(kts_pkg::MODE_LOOKUP, KEY_ZERO, KEY_ZERO, rand_wide(), 0);
		send_op(kts_pkg::MODE_DELETE, KEY_ZERO, KEY_ZERO, rand_wide(), 0);
		send_op(kts_pkg::MODE_DELETE, KEY_ZERO, KEY_ZERO, rand_wide(), 0);
		send_op(kts_pkg::MODE_INSERT, KEY_MIX, ~KEY_MIX, rand_wide(), 0);
		// Empty the table again, removing its first and then its only entry.
		send_op(kts_pkg::MODE_DELETE, KEY_ONES, KEY_ZERO, rand_wide(), 0);
		send_op(kts_pkg::MODE_DELETE, KEY_MIX, ~KEY_MIX, rand_wide(), 0);
		send_op(kts_pkg::MODE_LOOKUP, KEY_MIX, ~KEY_MIX, rand_wide(), 0);

		// Key pool for the random part. Odd slots share the first key part with the slot
		// before them, so only the second part tells those two apart.
		for (int i = 0; i < int'(POOL_SIZE); i++) begin
			pool_key_a[i] = (i % 2 == 1) ? pool_key_a[i-1] : rand_wide();
			pool_key_b[i] = rand_wide();
		end

		// Phase one: light sender gaps, inserts outweigh deletes so the table grows.
		repeat (PHASE_ITEMS)
			random_op(55, 21);
		// Phase two: heavy sender gaps; the table keeps growing until it fills up.
		repeat (PHASE_ITEMS)
			random_op(45, 69);
		// Phase three: back-to-back traffic. Mostly inserts first, which keeps the table
		// full and exercises the full report and the last positions; then mostly
		// searches and deletes so long compacting shifts run against a full table.
		repeat (PHASE_ITEMS / 2)
			random_op(75, 0);
		repeat (PHASE_ITEMS / 2)
			random_op(10, 0);
		start <= 1'b0;

		// Wait for every result, then give a stray strobe time to show up.
		while (checked_total != accepted_total)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d transactions: %0d inserts, %0d lookups, %0d updates, %0d deletes.",
			accepted_total, sent_by_op[kts_pkg::MODE_INSERT],
			sent_by_op[kts_pkg::MODE_LOOKUP], sent_by_op[kts_pkg::MODE_UPDATE],
			sent_by_op[kts_pkg::MODE_DELETE]);
		$display("Checked %0d results, %0d of them table-full reports; %0d mismatches.",
			checked_total, full_total, error_total);
		if (error_total == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
`default_nettype wire
